// ===== rtl/core/ccs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the C comment stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int FIFO_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        MODE_CODE   = 4'd0,
        MODE_SLASH  = 4'd1,
        MODE_LINE   = 4'd2,
        MODE_BLOCK  = 4'd3,
        MODE_BSTAR  = 4'd4,
        MODE_DQ     = 4'd5,
        MODE_DQ_ESC = 4'd6,
        MODE_SQ     = 4'd7,
        MODE_SQ_ESC = 4'd8
    } t_mode;

    // one queued input: one or two output bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef struct packed {
        logic phase;
    } t_back_status;

endpackage
`default_nettype wire

// ===== rtl/core/ccs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_front
// Lexer state machine: accepts bytes and classifies them into queue entries.
// ----------------------------------------------------------------------------
module ccs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_char,
    input  wire logic           i_last,
    input  wire logic           i_full,
    output logic                o_ready,
    output logic                o_push,
    output ccs_pkg::t_entry     o_entry,
    output ccs_pkg::t_mode      o_mode
);
    import ccs_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_mode  = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CODE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        cnt    = 2'd0;
        b0     = i_char;
        b1     = CH_SLASH;
        n_mode = MODE_CODE;
        case (r_mode)
            MODE_SLASH: begin
                if (i_char == CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else if (i_char == CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else begin
                    // held slash goes out, then the byte is treated as code
                    b0  = CH_SLASH;
                    cnt = 2'd1;
                    b1  = i_char;
                    if (i_char == CH_SLASH) begin
                        n_mode = MODE_SLASH;
                    end else begin
                        cnt = 2'd2;
                        if (i_char == CH_DQUOTE) n_mode = MODE_DQ;
                        else if (i_char == CH_SQUOTE) n_mode = MODE_SQ;
                        else n_mode = MODE_CODE;
                    end
                end
            end
            MODE_LINE: begin
                if (i_char == CH_NL) begin
                    cnt    = 2'd1;
                    n_mode = MODE_CODE;
                end else begin
                    n_mode = MODE_LINE;
                end
            end
            MODE_BLOCK: begin
                n_mode = (i_char == CH_STAR) ? MODE_BSTAR : MODE_BLOCK;
            end
            MODE_BSTAR: begin
                if (i_char == CH_SLASH) n_mode = MODE_CODE;
                else if (i_char == CH_STAR) n_mode = MODE_BSTAR;
                else n_mode = MODE_BLOCK;
            end
            MODE_DQ: begin
                cnt = 2'd1;
                if (i_char == CH_BSLASH) n_mode = MODE_DQ_ESC;
                else if (i_char == CH_DQUOTE) n_mode = MODE_CODE;
                else n_mode = MODE_DQ;
            end
            MODE_DQ_ESC: begin
                cnt    = 2'd1;
                n_mode = MODE_DQ;
            end
            MODE_SQ: begin
                cnt = 2'd1;
                if (i_char == CH_BSLASH) n_mode = MODE_SQ_ESC;
                else if (i_char == CH_SQUOTE) n_mode = MODE_CODE;
                else n_mode = MODE_SQ;
            end
            MODE_SQ_ESC: begin
                cnt    = 2'd1;
                n_mode = MODE_SQ;
            end
            default: begin
                if (i_char == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else begin
                    cnt = 2'd1;
                    if (i_char == CH_DQUOTE) n_mode = MODE_DQ;
                    else if (i_char == CH_SQUOTE) n_mode = MODE_SQ;
                    else n_mode = MODE_CODE;
                end
            end
        endcase

        // end of text flushes a held slash and returns to code
        if (i_last) begin
            if (n_mode == MODE_SLASH) begin
                if (cnt == 2'd0) begin
                    b0  = CH_SLASH;
                    cnt = 2'd1;
                end else begin
                    b1  = CH_SLASH;
                    cnt = 2'd2;
                end
            end
            n_mode = MODE_CODE;
        end
    end

    assign o_push      = accept && (cnt != 2'd0);
    assign o_entry.two = (cnt == 2'd2);
    assign o_entry.b0  = b0;
    assign o_entry.b1  = b1;

endmodule
`default_nettype wire

// ===== rtl/core/ccs_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_fifo
// Short register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module ccs_fifo #(
    parameter int DEPTH = ccs_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ccs_pkg::t_entry     i_entry,
    input  wire logic                i_pop,
    output ccs_pkg::t_entry          o_head,
    output ccs_pkg::t_fifo_status    o_status
);
    import ccs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ccs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_back
// Emitter: unpacks queue entries into output bytes behind an output register.
// ----------------------------------------------------------------------------
module ccs_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ccs_pkg::t_entry     i_head,
    input  wire logic                i_empty,
    output logic                     o_pop,
    input  wire logic                i_m_tready,
    output logic                     o_m_tvalid,
    output logic [7:0]               o_m_tdata,
    output logic                     o_m_tlast,
    output ccs_pkg::t_back_status    o_status
);
    import ccs_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_phase;
    logic       load;

    assign load  = (!r_valid || i_m_tready) && !i_empty;
    // pop once the final byte of the head entry is loaded
    assign o_pop = load && (r_phase || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_head.two;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= r_phase ? i_head.b1 : i_head.b0;
            r_last <= r_phase || !i_head.two;
        end
    end

    assign o_m_tvalid     = r_valid;
    assign o_m_tdata      = r_data;
    assign o_m_tlast      = r_last;
    assign o_status.phase = r_phase;

endmodule
`default_nettype wire

// ===== rtl/core/c_comment_stripper_core.sv =====
`default_nettype none
// a queue of FIFO_DEPTH entries holds kept bytes and absorbs output stalls
// throughput: one input byte per cycle unless the queue is full, one output
//   byte per cycle unless m_tready is low or nothing is queued; an input
//   that yields two bytes (held slash plus byte) leaves as two output bytes
// reset: synchronous active low, lexer returns to code mode, queue empties
// ----------------------------------------------------------------------------
// c_comment_stripper_core
// Removes C comments from a byte stream, keeping string and char literals.
// ----------------------------------------------------------------------------
module c_comment_stripper_core #(
    parameter int FIFO_DEPTH = ccs_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] char_out
    output logic            m_tlast    // last_of_run
);
    import ccs_pkg::*;

    logic         push;
    logic         pop;
    t_entry       entry;
    t_entry       head;
    t_mode        mode;
    t_fifo_status fifo_st;
    t_back_status back_st;

    ccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_char  (s_tdata),
        .i_last  (s_tlast),
        .i_full  (fifo_st.full),
        .o_ready (s_tready),
        .o_push  (push),
        .o_entry (entry),
        .o_mode  (mode)
    );

    ccs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (fifo_st)
    );

    ccs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (fifo_st.empty),
        .o_pop      (pop),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_status   (back_st)
    );

`ifndef SYNTH
    // end of text always leaves the lexer in code mode
    a_eot_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (mode == MODE_CODE))
        else $error("lexer not in code mode after end of text");

    // while the second byte of a pair is pending, the first is on the bus
    a_phase_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_st.phase |-> (m_tvalid && !m_tlast))
        else $error("pair pending without first byte shown");

    a_fifo_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_st.full && fifo_st.empty))
        else $error("queue both full and empty");

    // a pair is only started from a two-byte entry
    a_phase_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(back_st.phase) |-> $past(head.two))
        else $error("pair phase without two-byte entry");
`endif

endmodule
`default_nettype wire

// ===== tb/c_comment_stripper_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_comment_stripper_core_test
// Streams C-like text into the stripper, with random idle cycles on both
// sides. Output bytes are checked against a bench lexer or a directed row.
// ----------------------------------------------------------------------------
module c_comment_stripper_core_test;
    import ccs_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;  // expected bytes are given in the row
        int         cnt;
        logic [7:0] e0;
        logic [7:0] e1;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } kept_byte_t;

    localparam int N_DIRECTED = 27;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] char_in
    logic       s_tlast  = 1'b0;   // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] char_out
    logic       m_tlast;           // last_of_run

    t_mode      lex_mode = MODE_CODE;
    kept_byte_t kept_q[$];
    kept_byte_t want;
    stim_row_t  frag_q[$];
    int         mismatches = 0;
    int         sent = 0;
    int         hold_off = 0;
    logic       quiet = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00,     1'b0, 1'b1, 1, 8'h00,    8'h00},
        '{8'hFF,     1'b0, 1'b1, 1, 8'hFF,    8'h00},
        '{CH_SLASH,  1'b0, 1'b1, 0, 8'h00,    8'h00},
        '{8'h78,     1'b0, 1'b1, 2, CH_SLASH, 8'h78},
        '{CH_SLASH,  1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_NL,     1'b0, 1'b1, 1, CH_NL,    8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_STAR,   1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_STAR,   1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_STAR,   1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{8'h62,     1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_STAR,   1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_DQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_DQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_NL,     1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_DQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_BSLASH, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SLASH,  1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{CH_DQUOTE, 1'b0, 1'b0, 0, 8'h00,    8'h00},
        '{8'h7A,     1'b1, 1'b0, 0, 8'h00,    8'h00},
        '{CH_SLASH,  1'b1, 1'b1, 1, CH_SLASH, 8'h00}
    };

    c_comment_stripper_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // advances the lexer by one byte, returns the number of bytes it keeps
    function automatic int strip_step(input logic [7:0] c, input logic fin,
                                      output logic [7:0] o0, output logic [7:0] o1);
        logic [7:0] outs [2];
        int         n;
        logic       as_code;
        t_mode      nxt;
        n       = 0;
        as_code = 1'b0;
        nxt     = lex_mode;
        outs[0] = 8'h00;
        outs[1] = 8'h00;
        case (lex_mode)
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    nxt = MODE_LINE;
                end else if (c == CH_STAR) begin
                    nxt = MODE_BLOCK;
                end else begin
                    // held slash goes out, then the byte is plain code
                    outs[n] = CH_SLASH;
                    n++;
                    as_code = 1'b1;
                end
            end
            MODE_LINE: begin
                if (c == CH_NL) begin
                    outs[n] = c;
                    n++;
                    nxt = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) nxt = MODE_BSTAR;
            end
            MODE_BSTAR: begin
                if (c == CH_SLASH) nxt = MODE_CODE;
                else if (c != CH_STAR) nxt = MODE_BLOCK;
            end
            MODE_DQ, MODE_SQ: begin
                outs[n] = c;
                n++;
                if (c == CH_BSLASH) begin
                    nxt = (lex_mode == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
                end else if (c == ((lex_mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
                    nxt = MODE_CODE;
                end
            end
            MODE_DQ_ESC: begin
                outs[n] = c;
                n++;
                nxt = MODE_DQ;
            end
            MODE_SQ_ESC: begin
                outs[n] = c;
                n++;
                nxt = MODE_SQ;
            end
            default: begin
                as_code = 1'b1;
            end
        endcase
        if (as_code) begin
            if (c == CH_SLASH) begin
                nxt = MODE_SLASH;
            end else begin
                outs[n] = c;
                n++;
                if (c == CH_DQUOTE) nxt = MODE_DQ;
                else if (c == CH_SQUOTE) nxt = MODE_SQ;
                else nxt = MODE_CODE;
            end
        end
        if (fin) begin
            if (nxt == MODE_SLASH) begin
                outs[n] = CH_SLASH;
                n++;
            end
            nxt = MODE_CODE;
        end
        lex_mode = nxt;
        o0 = outs[0];
        o1 = outs[1];
        return n;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rnd_pick();
        case ($urandom_range(0, 11))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_NL;
            3: return CH_DQUOTE;
            4: return CH_SQUOTE;
            5: return CH_BSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] c);
        frag_q.push_back('{c, ($urandom_range(0, 49) == 0), 1'b0, 0, 8'h00, 8'h00});
    endtask

    // drives one transaction and records what the stripper should keep
    task automatic send_byte(input stim_row_t r);
        int         gap;
        int         n;
        logic [7:0] p0;
        logic [7:0] p1;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.ch;
        s_tlast  <= r.fin;
        do @(posedge i_clk); while (!s_tready);
        n = strip_step(r.ch, r.fin, p0, p1);
        if (r.typed) begin
            n  = r.cnt;
            p0 = r.e0;
            p1 = r.e1;
        end
        if (n > 0) kept_q.push_back('{p0, (n == 1)});
        if (n > 1) kept_q.push_back('{p1, 1'b1});
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (kept_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver side: random stalls on m_tready
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold_off = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (kept_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %b", m_tdata, m_tlast));
            end else begin
                want = kept_q.pop_front();
                if (m_tdata !== want.ch) begin
                    report_mismatch($sformatf("char_out %02h, want %02h", m_tdata, want.ch));
                end
                if (m_tlast !== want.lst) begin
                    report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                              m_tlast, want.lst, want.ch));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int         kind;
        int         len;
        logic       paused;
        logic [7:0] b;
        paused = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(directed_rows[i]);
        end
        wait_drained();

        while (sent < 620) begin
            quiet = (sent >= 250 && sent < 350);
            if (!paused && sent >= 450) begin
                wait_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            len  = $urandom_range(0, 8);
            case (kind)
                0, 1, 2: begin
                    repeat (len + 1) begin
                        add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(8'h61, 8'h7A)));
                    end
                end
                3: begin
                    add_byte(CH_SLASH);
                    add_byte(CH_SLASH);
                    repeat (len) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_NL) b = 8'h20;
                        add_byte(b);
                    end
                    if ($urandom_range(0, 4) != 0) add_byte(CH_NL);
                end
                4: begin
                    add_byte(CH_SLASH);
                    add_byte(CH_STAR);
                    repeat (len) begin
                        add_byte(($urandom_range(0, 2) == 0) ? CH_STAR
                                                             : 8'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 6) != 0) begin
                        add_byte(CH_STAR);
                        add_byte(CH_SLASH);
                    end
                end
                5: begin
                    add_byte(CH_DQUOTE);
                    repeat (len) begin
                        if ($urandom_range(0, 4) == 0) begin
                            add_byte(CH_BSLASH);
                            add_byte(8'($urandom_range(0, 255)));
                        end else begin
                            b = 8'($urandom_range(0, 255));
                            if (b == CH_DQUOTE || b == CH_BSLASH) b = 8'h71;
                            add_byte(b);
                        end
                    end
                    if ($urandom_range(0, 9) != 0) add_byte(CH_DQUOTE);
                end
                6: begin
                    add_byte(CH_SQUOTE);
                    if ($urandom_range(0, 2) == 0) add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(CH_SQUOTE);
                end
                7: begin
                    add_byte(CH_SLASH);
                    add_byte(rnd_pick());
                end
                default: begin
                    repeat (len % 4 + 1) add_byte(rnd_pick());
                end
            endcase
            while (frag_q.size() > 0) begin
                send_byte(frag_q.pop_front());
                sent++;
            end
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
